// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

    // Fixed UTF-8 / UTF-16 constants
    localparam logic [20:0] REPL_CP     = 21'h00FFFD;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
    localparam logic [20:0] CP_1B_MAX   = 21'h00007F;
    localparam logic [20:0] CP_2B_MAX   = 21'h0007FF;
    localparam logic [20:0] CP_SUPP_OFS = 21'h010000;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [4:0]  SURR_TOP    = 5'b11011;

    // Defaults
    localparam int          COUNT_BITS_DEF = 16;
    localparam logic [15:0] CAP_RESET      = 16'hFFFF;

    // Results one byte can cause, rounded up to a power of two
    localparam int SLOTS   = 4;
    localparam int SLOT_W  = $clog2(SLOTS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_CAPACITY = 2'd0,
        CFG_COUNT_ONLY   = 2'd1
    } t_cfg_idx;

    // One result item
    typedef struct packed {
        logic [15:0] code_unit;
        logic [15:0] unit_position;
        logic        is_terminator;
        logic [15:0] total_units;
    } t_result;

endpackage

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// An input transfer reaches its first result via two registers: input register, result register.
// Throughput: one byte per cycle while results are accepted and no byte causes more than one;
// a byte with k results holds the result register as the single port drains one item per cycle.
// Reset: synchronous, active low; clears the decoder, unit count and result register,
// and sets out_capacity to 65535 and count_only to 0. No clearing pass.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [7:0] in_byte
    input  logic                 i_s_axis_tlast,   // end_of_string
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [47:0]          o_m_axis_tdata,   // [15:0] code_unit, [31:16] unit_position,
                                                   // [47:32] total_units
    output logic                 o_m_axis_tuser,   // is_terminator
    output logic                 o_m_axis_tlast,   // run_last
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int CNT_W = (COUNT_BITS > 16) ? 16 : COUNT_BITS;
    localparam int CW1   = CNT_W + 1;
    localparam logic [CNT_W:0] LIM = {1'b0, {CNT_W{1'b1}}};

    typedef struct packed {
        logic [CNT_W-1:0] u_next;
        logic [1:0]       n;
        logic [15:0]      w0;
        logic [15:0]      w1;
    } t_emit;

    // Place one code point: units, their count and the updated unit count
    function automatic t_emit f_emit(input logic [20:0]      cp,
                                     input logic [CNT_W-1:0] u,
                                     input logic [15:0]      cap_reg,
                                     input logic             cnt_mode);
        t_emit          e;
        logic           need2;
        logic [CNT_W:0] sum;
        logic [CNT_W:0] cap;
        logic [16:0]    capx;
        logic [19:0]    v;
        need2 = (cp > CP_BMP_MAX);
        sum   = {1'b0, u} + (need2 ? CW1'(2) : CW1'(1));
        capx  = {1'b0, cap_reg};
        cap   = (capx > 17'(LIM)) ? LIM : CW1'(capx);
        v     = 20'(cp - CP_SUPP_OFS);
        e.w0  = need2 ? (HI_SURR | {6'd0, v[19:10]}) : cp[15:0];
        e.w1  = LO_SURR | {6'd0, v[9:0]};
        if (cnt_mode) begin
            e.n      = 2'd0;
            e.u_next = (sum > LIM) ? LIM[CNT_W-1:0] : sum[CNT_W-1:0];
        end else if (sum > cap) begin
            e.n      = 2'd0;
            e.u_next = u;
        end else begin
            e.n      = need2 ? 2'd2 : 2'd1;
            e.u_next = sum[CNT_W-1:0];
        end
        return e;
    endfunction

    // Configuration registers
    logic [15:0] r_cap;
    logic        r_cnt_only;

    // Input register
    logic       r_iv;
    logic [7:0] r_byte;
    logic       r_eos;

    // Decoder state
    logic [1:0]       r_rem,  n_rem;
    logic [2:0]       r_len,  n_len;
    logic [20:0]      r_part, n_part;
    logic [CNT_W-1:0] r_ucnt, n_ucnt;

    // Result register
    t_result           r_slot [SLOTS];
    t_result           n_slot [SLOTS];
    logic [SLOT_W:0]   r_cnt, r_rd, n_items;

    logic in_xfer, out_xfer, out_last, slot_free, adv;

    assign o_cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_cnt_only <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OUT_CAPACITY: r_cap      <= i_cfg_data;
                CFG_COUNT_ONLY:   r_cnt_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign o_m_axis_tvalid = (r_rd != r_cnt);
    assign out_xfer        = o_m_axis_tvalid && i_m_axis_tready;
    assign out_last        = ((r_rd + 1'b1) == r_cnt);
    assign slot_free       = !o_m_axis_tvalid || (out_xfer && out_last);
    assign adv             = r_iv && slot_free;
    assign o_s_axis_tready = !r_iv || slot_free;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Hold the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_xfer) begin
            r_iv <= 1'b1;
        end else if (adv) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte <= i_s_axis_tdata;
            r_eos  <= i_s_axis_tlast;
        end
    end

    // Decode one byte
    logic        a_en, b_en, do_lead, cont;
    logic [20:0] a_cp, b_cp, fin_cp;
    logic [2:0]  proper;
    logic        bad;
    t_emit       ea, eb;
    logic [CNT_W-1:0] ua, ub;
    t_result     ent [SLOTS];
    logic [SLOTS-1:0] ent_v;
    logic [SLOT_W:0]  idx;

    always_comb begin
        cont    = (r_byte[7:6] == 2'b10);
        a_en    = 1'b0;
        b_en    = 1'b0;
        a_cp    = REPL_CP;
        b_cp    = REPL_CP;
        do_lead = 1'b0;
        n_rem   = r_rem;
        n_len   = r_len;
        n_part  = r_part;
        fin_cp  = {r_part[14:0], r_byte[5:0]};
        proper  = (fin_cp <= CP_1B_MAX)  ? 3'd1 :
                  (fin_cp <= CP_2B_MAX)  ? 3'd2 :
                  (fin_cp <= CP_BMP_MAX) ? 3'd3 : 3'd4;
        bad     = (proper != r_len)
               || (fin_cp < CP_BMP_MAX && fin_cp[20:16] == 5'd0 && fin_cp[15:11] == SURR_TOP)
               || (fin_cp > CP_MAX);

        // continuation or broken sequence
        if (r_rem != 2'd0) begin
            if (cont) begin
                n_part = fin_cp;
                n_rem  = r_rem - 2'd1;
                if (n_rem == 2'd0) begin
                    a_en   = 1'b1;
                    a_cp   = bad ? REPL_CP : fin_cp;
                    n_len  = 3'd0;
                    n_part = 21'd0;
                end else if (r_eos) begin
                    a_en   = 1'b1;
                    n_rem  = 2'd0;
                    n_len  = 3'd0;
                    n_part = 21'd0;
                end
            end else begin
                a_en    = 1'b1;
                n_rem   = 2'd0;
                n_len   = 3'd0;
                n_part  = 21'd0;
                do_lead = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        // lead byte
        if (do_lead) begin
            if (!r_byte[7]) begin
                b_en = 1'b1;
                b_cp = {13'd0, r_byte};
            end else if (r_byte[7:5] == 3'b110) begin
                n_len  = 3'd2;
                n_rem  = 2'd1;
                n_part = {16'd0, r_byte[4:0]};
                b_en   = r_eos;
            end else if (r_byte[7:4] == 4'b1110) begin
                n_len  = 3'd3;
                n_rem  = 2'd2;
                n_part = {17'd0, r_byte[3:0]};
                b_en   = r_eos;
            end else if (r_byte[7:3] == 5'b11110) begin
                n_len  = 3'd4;
                n_rem  = 2'd3;
                n_part = {18'd0, r_byte[2:0]};
                b_en   = r_eos;
            end else begin
                b_en = 1'b1;
            end
        end

        // place the code points in order
        ea = f_emit(a_cp, r_ucnt, r_cap, r_cnt_only);
        ua = a_en ? ea.u_next : r_ucnt;
        eb = f_emit(b_cp, ua, r_cap, r_cnt_only);
        ub = b_en ? eb.u_next : ua;

        for (int i = 0; i < SLOTS; i++) begin
            ent[i] = '0;
        end
        ent[0].code_unit     = ea.w0;
        ent[0].unit_position = 16'(r_ucnt);
        ent[1].code_unit     = ea.w1;
        ent[1].unit_position = 16'(r_ucnt) + 16'd1;
        ent[2].code_unit     = eb.w0;
        ent[2].unit_position = 16'(ua);
        ent[3].is_terminator = 1'b1;
        ent[3].total_units   = 16'(ub);
        ent_v[0] = a_en && (ea.n != 2'd0);
        ent_v[1] = a_en && (ea.n == 2'd2);
        ent_v[2] = b_en && (eb.n != 2'd0);
        ent_v[3] = r_eos;

        // close the string
        n_ucnt = ub;
        if (r_eos) begin
            n_ucnt = '0;
            n_rem  = 2'd0;
            n_len  = 3'd0;
            n_part = 21'd0;
        end

        // pack the valid results to the front
        for (int i = 0; i < SLOTS; i++) begin
            n_slot[i] = '0;
        end
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (ent_v[i]) begin
                n_slot[idx[SLOT_W-1:0]] = ent[i];
                idx = idx + 1'b1;
            end
        end
        n_items = idx;
    end

    // Advance decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 2'd0;
            r_len  <= 3'd0;
            r_part <= 21'd0;
            r_ucnt <= '0;
        end else if (adv) begin
            r_rem  <= n_rem;
            r_len  <= n_len;
            r_part <= n_part;
            r_ucnt <= n_ucnt;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (adv) begin
            r_cnt <= n_items;
            r_rd  <= '0;
        end else if (out_xfer) begin
            r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    // Present the current result
    t_result cur;
    assign cur            = r_slot[r_rd[SLOT_W-1:0]];
    assign o_m_axis_tdata = {cur.total_units, cur.unit_position, cur.code_unit};
    assign o_m_axis_tuser = cur.is_terminator;
    assign o_m_axis_tlast = out_last;

`ifndef SYNTHESIS
    a_bundle_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 3'd3) && (r_rd <= r_cnt))
        else $error("result register holds too many items");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("terminator is not the last result of its byte");

    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 2'd0) |-> ((r_len > {1'b0, r_rem}) && (r_len <= 3'd4)))
        else $error("pending sequence length disagrees with remaining count");

    a_string_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_eos) |=> (r_ucnt == '0) && (r_rem == 2'd0))
        else $error("decoder not cleared after end of string");
`endif

endmodule
